// ----- hw/rtl/assert_macros.svh -----
// assertion macros shared by the checker files
// no dependencies; include guard below
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, off while reset is asserted
`define GAF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// clocked assertion that also holds during reset
`define GAF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ----- hw/rtl/gaf_pkg.sv -----
// types, widths and constants of the genotype allele frequency core
// no dependencies
package gaf_pkg;

  localparam int WORD_W      = 64;
  localparam int SAMPLE_W    = 17;
  localparam int SUM_W       = 18;
  localparam int FRAC_BITS   = 16;
  localparam int Q_W         = 17;
  localparam int MAX_SAMPLES = 65536;
  localparam int DIV_W       = 19;
  localparam int POP_W       = 7;
  localparam int STEP_W      = $clog2(FRAC_BITS + 1);
  localparam int QUEUE_DEPTH = 2;

  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
  localparam logic [Q_W-1:0]   Q_ONE   = Q_W'(1 << FRAC_BITS);

  typedef struct packed {
    logic [WORD_W-1:0] geno_word;
    logic              last_word;
  } gaf_in_t;

  typedef struct packed {
    logic [SUM_W-1:0] allele_count;
    logic [SUM_W-1:0] nonmissing_count;
    logic [Q_W-1:0]   allele_freq;
    logic [Q_W-1:0]   call_rate;
    logic             no_calls;
  } gaf_out_t;

  // per-marker sums handed from front to back
  typedef struct packed {
    logic [SUM_W-1:0] allele_sum;
    logic [SUM_W-1:0] called_sum;
  } gaf_tally_t;

  typedef struct packed {
    logic empty;
    logic full;
  } gaf_q_status_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] num;
    logic [DIV_W-1:0] den;
  } gaf_div_req_t;

  typedef struct packed {
    logic           done;
    logic [Q_W-1:0] quo;
  } gaf_div_rsp_t;

endpackage

// ----- hw/rtl/gaf_front.sv -----
// front end: decodes genotype words, counts alleles and calls, sums per marker
// depends on gaf_pkg
module gaf_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  gaf_pkg::gaf_in_t    in_data_i,
  input  logic                q_full_i,
  output logic                q_push_o,
  output gaf_pkg::gaf_tally_t q_data_o
);
  import gaf_pkg::*;

  // adds 32 two-bit values through a balanced tree
  function automatic logic [POP_W-1:0] tree_sum(input logic [WORD_W-1:0] v);
    logic [2:0] l1 [16];
    logic [3:0] l2 [8];
    logic [4:0] l3 [4];
    logic [5:0] l4 [2];
    for (int i = 0; i < 16; i++) l1[i] = {1'b0, v[4*i +: 2]} + {1'b0, v[4*i+2 +: 2]};
    for (int i = 0; i < 8; i++)  l2[i] = {1'b0, l1[2*i]} + {1'b0, l1[2*i+1]};
    for (int i = 0; i < 4; i++)  l3[i] = {1'b0, l2[2*i]} + {1'b0, l2[2*i+1]};
    for (int i = 0; i < 2; i++)  l4[i] = {1'b0, l3[2*i]} + {1'b0, l3[2*i+1]};
    return {1'b0, l4[0]} + {1'b0, l4[1]};
  endfunction

  logic [SUM_W-1:0]  allele_q, allele_d;
  logic [SUM_W-1:0]  called_q, called_d;
  logic [WORD_W-1:0] called_vec, allele_vec;
  logic [POP_W-1:0]  called_pop, allele_pop;
  logic [SUM_W:0]    allele_ext, called_ext;
  logic              accept;

  // code 01 is missing; called samples weigh two, alleles weigh their set bits
  always_comb begin
    for (int i = 0; i < WORD_W / 2; i++) begin
      logic hi, lo, called;
      hi = in_data_i.geno_word[2*i+1];
      lo = in_data_i.geno_word[2*i];
      called = hi | ~lo;
      called_vec[2*i +: 2] = {called, 1'b0};
      allele_vec[2*i +: 2] = called ? {hi & lo, hi ^ lo} : 2'b00;
    end
  end

  assign called_pop = tree_sum(called_vec);
  assign allele_pop = tree_sum(allele_vec);

  assign allele_ext = {1'b0, allele_q} + (SUM_W+1)'(allele_pop);
  assign called_ext = {1'b0, called_q} + (SUM_W+1)'(called_pop);
  assign allele_d   = allele_ext[SUM_W] ? SUM_MAX : allele_ext[SUM_W-1:0];
  assign called_d   = called_ext[SUM_W] ? SUM_MAX : called_ext[SUM_W-1:0];

  assign in_ready_o = ~q_full_i;
  assign accept     = in_valid_i & in_ready_o;
  assign q_push_o   = accept & in_data_i.last_word;
  assign q_data_o   = '{allele_sum: allele_d, called_sum: called_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      allele_q <= '0;
      called_q <= '0;
    end else if (accept) begin
      if (in_data_i.last_word) begin
        allele_q <= '0;
        called_q <= '0;
      end else begin
        allele_q <= allele_d;
        called_q <= called_d;
      end
    end
  end

endmodule

// ----- hw/rtl/gaf_queue.sv -----
// small queue of finished marker sums between front and back
// depends on gaf_pkg
module gaf_queue #(
  parameter int Depth = gaf_pkg::QUEUE_DEPTH
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  gaf_pkg::gaf_tally_t   push_data_i,
  input  logic                  pop_i,
  output gaf_pkg::gaf_tally_t   head_o,
  output gaf_pkg::gaf_q_status_t status_o
);
  import gaf_pkg::*;

  localparam int PTR_W = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CNT_W = $clog2(Depth + 1);

  gaf_tally_t       entry_q [Depth];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;
  logic             do_push, do_pop;

  assign status_o.empty = (count_q == '0);
  assign status_o.full  = (count_q == CNT_W'(Depth));
  assign do_push = push_i & ~status_o.full;
  assign do_pop  = pop_i & ~status_o.empty;
  assign head_o  = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

// ----- hw/rtl/gaf_divider.sv -----
// shared restoring divider, one quotient bit a cycle, saturates at one
// depends on gaf_pkg
module gaf_divider (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  gaf_pkg::gaf_div_req_t req_i,
  output gaf_pkg::gaf_div_rsp_t rsp_o
);
  import gaf_pkg::*;

  typedef enum logic [0:0] {DV_IDLE, DV_RUN} state_e;

  state_e            state_q;
  logic [DIV_W-1:0]  rem_q, den_q, rem_nx;
  logic [DIV_W:0]    rem_sh;
  logic [Q_W-1:0]    quo_q;
  logic [STEP_W-1:0] cnt_q;
  logic              done_q, ge;

  assign rem_sh = {rem_q, 1'b0};
  assign ge     = rem_sh >= {1'b0, den_q};
  assign rem_nx = ge ? DIV_W'(rem_sh - {1'b0, den_q}) : rem_sh[DIV_W-1:0];

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DV_IDLE;
      done_q  <= 1'b0;
      cnt_q   <= '0;
      rem_q   <= '0;
      den_q   <= '0;
      quo_q   <= '0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        DV_IDLE: begin
          if (req_i.start) begin
            if (req_i.den == '0) begin
              quo_q  <= '0;
              done_q <= 1'b1;
            end else if (req_i.num >= req_i.den) begin
              // ratio of one or more clips to one
              quo_q  <= Q_ONE;
              done_q <= 1'b1;
            end else begin
              rem_q   <= req_i.num;
              den_q   <= req_i.den;
              quo_q   <= '0;
              cnt_q   <= STEP_W'(FRAC_BITS);
              state_q <= DV_RUN;
            end
          end
        end
        DV_RUN: begin
          rem_q <= rem_nx;
          quo_q <= {quo_q[Q_W-2:0], ge};
          cnt_q <= cnt_q - 1'b1;
          if (cnt_q == STEP_W'(1)) begin
            done_q  <= 1'b1;
            state_q <= DV_IDLE;
          end
        end
        default: state_q <= DV_IDLE;
      endcase
    end
  end

endmodule

// ----- hw/rtl/gaf_back.sv -----
// back end: padding correction, frequency and call rate, result register
// depends on gaf_pkg, gaf_divider
module gaf_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [gaf_pkg::SAMPLE_W-1:0]  sample_count_i,
  input  gaf_pkg::gaf_q_status_t        q_status_i,
  input  gaf_pkg::gaf_tally_t           q_head_i,
  output logic                          q_pop_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output gaf_pkg::gaf_out_t             out_data_o
);
  import gaf_pkg::*;

  typedef enum logic [2:0] {
    BK_IDLE, BK_FREQ_GO, BK_FREQ_WAIT, BK_RATE_GO, BK_RATE_WAIT
  } state_e;

  state_e              state_q;
  logic [SUM_W-1:0]    allele_q, nm_q, nm_c;
  logic [DIV_W-1:0]    den2_q;
  logic [Q_W-1:0]      freq_q;
  logic [SAMPLE_W-1:0] n_clamp;
  logic [SUM_W-1:0]    corr;
  logic                out_valid_q;
  gaf_out_t            out_q;
  gaf_div_req_t        div_req;
  gaf_div_rsp_t        div_rsp;

  assign n_clamp = (sample_count_i > SAMPLE_W'(MAX_SAMPLES)) ?
                   SAMPLE_W'(MAX_SAMPLES) : sample_count_i;
  // twice the unused slots in the last byte
  assign corr = SUM_W'({2'(2'd0 - n_clamp[1:0]), 1'b0});
  assign nm_c = (q_head_i.called_sum > corr) ? q_head_i.called_sum - corr : '0;

  assign q_pop_o = (state_q == BK_IDLE) && !q_status_i.empty;

  always_comb begin
    div_req.start = (state_q == BK_FREQ_GO) || ((state_q == BK_RATE_GO) && !out_valid_q);
    if (state_q == BK_FREQ_GO) begin
      div_req.num = DIV_W'(allele_q);
      div_req.den = DIV_W'(nm_q);
    end else begin
      div_req.num = DIV_W'(nm_q);
      div_req.den = den2_q;
    end
  end

  gaf_divider u_divider (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      out_valid_q <= 1'b0;
      allele_q    <= '0;
      nm_q        <= '0;
      den2_q      <= '0;
      freq_q      <= '0;
      out_q       <= '0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        BK_IDLE: begin
          if (!q_status_i.empty) begin
            allele_q <= q_head_i.allele_sum;
            nm_q     <= nm_c;
            den2_q   <= DIV_W'({n_clamp, 1'b0});
            state_q  <= BK_FREQ_GO;
          end
        end
        BK_FREQ_GO: state_q <= BK_FREQ_WAIT;
        BK_FREQ_WAIT: begin
          if (div_rsp.done) begin
            freq_q  <= div_rsp.quo;
            state_q <= BK_RATE_GO;
          end
        end
        BK_RATE_GO: begin
          // result slot must be free before the last division finishes
          if (!out_valid_q) begin
            state_q <= BK_RATE_WAIT;
          end
        end
        BK_RATE_WAIT: begin
          if (div_rsp.done) begin
            out_q.allele_count     <= allele_q;
            out_q.nonmissing_count <= nm_q;
            out_q.allele_freq      <= freq_q;
            out_q.call_rate        <= div_rsp.quo;
            out_q.no_calls         <= (nm_q == '0);
            out_valid_q            <= 1'b1;
            state_q                <= BK_IDLE;
          end
        end
        default: state_q <= BK_IDLE;
      endcase
    end
  end

endmodule

// ----- hw/rtl/genotype_allele_frequency_core.sv -----
// top level of the genotype allele frequency core: config register, front, queue, back
// depends on gaf_pkg, gaf_front, gaf_queue, gaf_back
//
//   channel   signals                        direction   moves
//   in        in_valid_i/in_ready_o/in_data  sink        one 64-bit genotype word
//   out       out_valid_o/out_ready_i/out_*  source      one marker result
//   apb       psel/penable/pwrite/paddr      slave       sample_count at offset 0
//
// the front takes one word per cycle and stalls only when the queue is full
// the back runs both divisions of a marker one after the other in the shared divider,
// skipping the bit-serial steps when a ratio clips to one or has a zero divisor
// up to QueueDepth finished markers wait between the two halves
// reset clears sums, queue, divider and output valid; sample_count resets to 1
// a waiting result does not stop the next marker's frequency division
module genotype_allele_frequency_core #(
  parameter int QueueDepth = gaf_pkg::QUEUE_DEPTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  gaf_pkg::gaf_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output gaf_pkg::gaf_out_t out_data_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import gaf_pkg::*;

  logic [SAMPLE_W-1:0] sample_count_q;
  logic                q_push, q_pop;
  gaf_tally_t          q_push_data, q_head;
  gaf_q_status_t       q_status;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? 32'(sample_count_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_count_q <= SAMPLE_W'(1);
    end else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
      sample_count_q <= pwdata[SAMPLE_W-1:0];
    end
  end

  gaf_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .q_full_i   (q_status.full),
    .q_push_o   (q_push),
    .q_data_o   (q_push_data)
  );

  gaf_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_push_data),
    .pop_i       (q_pop),
    .head_o      (q_head),
    .status_o    (q_status)
  );

  gaf_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .sample_count_i (sample_count_q),
    .q_status_i     (q_status),
    .q_head_i       (q_head),
    .q_pop_o        (q_pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_data_o     (out_data_o)
  );

endmodule

// ----- hw/rtl/gaf_checker.sv -----
// port-level checks of the genotype allele frequency core, bound to the top level
// depends on gaf_pkg, assert_macros.svh, genotype_allele_frequency_core
`include "assert_macros.svh"

module gaf_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input gaf_pkg::gaf_in_t  in_data_i,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input gaf_pkg::gaf_out_t out_data_o,
  input logic              psel,
  input logic              penable,
  input logic              pwrite,
  input logic [2:0]        paddr,
  input logic [31:0]       pwdata,
  input logic [31:0]       prdata,
  input logic              pready
);
  import gaf_pkg::*;

  `GAF_ASSERT(out_valid_holds, out_valid_o && !out_ready_i |=> out_valid_o, "result dropped while stalled")
  `GAF_ASSERT(out_data_holds, out_valid_o && !out_ready_i |=> $stable(out_data_o), "result changed while stalled")
  `GAF_ASSERT(no_calls_match, out_valid_o |-> (out_data_o.no_calls == (out_data_o.nonmissing_count == '0)), "no_calls disagrees with count")
  `GAF_ASSERT(no_calls_freq_zero, out_valid_o && out_data_o.no_calls |-> (out_data_o.allele_freq == '0), "frequency not zero without calls")
  `GAF_ASSERT(fractions_in_range, out_valid_o |-> (out_data_o.allele_freq <= Q_ONE) && (out_data_o.call_rate <= Q_ONE), "fraction above one")

endmodule

bind genotype_allele_frequency_core gaf_checker u_gaf_checker (.*);

// ----- tb/sv/allele_frequency_checker.sv -----
`timescale 1ns / 1ps
// checker for genotype_allele_frequency_core: shadows sample_count, sums each marker's words
// and compares every marker result with its prediction; depends on gaf_pkg
module allele_frequency_checker
  import gaf_pkg::*;
#(
  parameter logic [2:0] SampleCountAddr = 3'd0
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  gaf_in_t     in_data_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  gaf_out_t    out_data_i,
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic        pready_i,
  input  logic [2:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  output int unsigned pending_o,
  output int unsigned fail_count_o
);

  localparam logic [1:0]        CODE_MISSING = 2'b01;
  localparam logic [WORD_W-1:0] MISSING_WORD = {(WORD_W / 2){CODE_MISSING}};

  logic [SAMPLE_W-1:0] samples_q;
  logic [SUM_W-1:0]    allele_tally_q;
  logic [SUM_W-1:0]    called_tally_q;
  gaf_out_t            marker_results_q[$];

  function automatic logic [SUM_W-1:0] add_capped(logic [SUM_W-1:0] acc, int unsigned inc);
    longint unsigned total;
    total = acc + inc;
    return (total > SUM_MAX) ? SUM_MAX : SUM_W'(total);
  endfunction

  // floored q1.16 ratio, capped at one, zero for an empty divisor
  function automatic logic [Q_W-1:0] q_fraction(longint unsigned num, longint unsigned den);
    longint unsigned q;
    if (den == 0) return '0;
    q = (num << FRAC_BITS) / den;
    return (q > Q_ONE) ? Q_ONE : Q_W'(q);
  endfunction

  function automatic gaf_out_t close_marker(logic [SUM_W-1:0] alleles,
                                            logic [SUM_W-1:0] called,
                                            logic [SAMPLE_W-1:0] samples);
    gaf_out_t        res;
    longint unsigned n;
    longint unsigned pad;
    longint unsigned nm;
    n   = (samples > MAX_SAMPLES) ? MAX_SAMPLES : samples;
    // unused codes of the last byte are 00 and were counted as called
    pad = 2 * ((4 - (n & 3)) & 3);
    nm  = (called > pad) ? called - pad : 0;
    res.allele_count     = alleles;
    res.nonmissing_count = SUM_W'(nm);
    res.allele_freq      = q_fraction(alleles, nm);
    res.call_rate        = q_fraction(nm, 2 * n);
    res.no_calls         = (nm == 0);
    return res;
  endfunction

  function automatic int unsigned field_miss(string name, logic [SUM_W-1:0] exp_v,
                                             logic [SUM_W-1:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    logic [WORD_W-1:0] flip;
    logic [WORD_W-1:0] called_mask;
    logic [SUM_W-1:0]  alleles;
    logic [SUM_W-1:0]  called;
    gaf_out_t          want;
    int unsigned       fails;
    if (!rst_ni) begin
      samples_q      <= SAMPLE_W'(1);
      allele_tally_q <= '0;
      called_tally_q <= '0;
      marker_results_q.delete();
      pending_o      <= 0;
      fail_count_o   <= 0;
    end else begin
      fails = fail_count_o;
      if (psel_i && penable_i && pwrite_i && pready_i && paddr_i == SampleCountAddr) begin
        samples_q <= pwdata_i[SAMPLE_W-1:0];
      end
      if (out_valid_i && out_ready_i) begin
        if (marker_results_q.size() == 0) begin
          $error("marker result with none expected: allele_count %0d",
                 out_data_i.allele_count);
          fails++;
        end else begin
          want = marker_results_q.pop_front();
          fails += field_miss("allele_count", want.allele_count, out_data_i.allele_count);
          fails += field_miss("nonmissing_count", want.nonmissing_count,
                              out_data_i.nonmissing_count);
          fails += field_miss("allele_freq", want.allele_freq, out_data_i.allele_freq);
          fails += field_miss("call_rate", want.call_rate, out_data_i.call_rate);
          fails += field_miss("no_calls", want.no_calls, out_data_i.no_calls);
        end
      end
      if (in_valid_i && in_ready_i) begin
        // a sample is called unless its code is 01
        flip        = in_data_i.geno_word ^ MISSING_WORD;
        called_mask = (flip | (flip >> 1)) & MISSING_WORD;
        called_mask = called_mask | (called_mask << 1);
        alleles = add_capped(allele_tally_q, $countones(called_mask & in_data_i.geno_word));
        called  = add_capped(called_tally_q, $countones(called_mask));
        if (in_data_i.last_word) begin
          marker_results_q.push_back(close_marker(alleles, called, samples_q));
          allele_tally_q <= '0;
          called_tally_q <= '0;
        end else begin
          allele_tally_q <= alleles;
          called_tally_q <= called;
        end
      end
      pending_o    <= marker_results_q.size();
      fail_count_o <= fails;
    end
  end

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
// top of the genotype_allele_frequency_core testbench: clock, reset, genotype word and
// sample_count stimulus, verdict; depends on gaf_pkg, the core and allele_frequency_checker
module testbench;
  import gaf_pkg::*;

  localparam logic [2:0]        REG_SAMPLE_COUNT = 3'd0;
  localparam logic [1:0]        CODE_HOM_REF     = 2'b00;
  localparam logic [1:0]        CODE_MISSING     = 2'b01;
  localparam logic [1:0]        CODE_HET         = 2'b10;
  localparam logic [1:0]        CODE_HOM_ALT     = 2'b11;
  localparam logic [WORD_W-1:0] MISSING_ALL      = {(WORD_W / 2){CODE_MISSING}};
  localparam int                SETTLE_CYCLES    = 64;
  localparam int                RANDOM_WORDS     = 1000;

  logic        clk_i     = 1'b0;
  logic        rst_ni    = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  gaf_in_t     in_data   = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  gaf_out_t    out_data;
  logic        psel      = 1'b0;
  logic        penable   = 1'b0;
  logic        pwrite    = 1'b0;
  logic [2:0]  paddr     = '0;
  logic [31:0] pwdata    = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        calm      = 1'b0;
  int unsigned words_sent = 0;
  int unsigned pending;
  int unsigned fail_count;

  genotype_allele_frequency_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  allele_frequency_checker #(
    .SampleCountAddr (REG_SAMPLE_COUNT)
  ) checker_inst (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_data_i   (out_data),
    .psel_i       (psel),
    .penable_i    (penable),
    .pwrite_i     (pwrite),
    .pready_i     (pready),
    .paddr_i      (paddr),
    .pwdata_i     (pwdata),
    .pending_o    (pending),
    .fail_count_o (fail_count)
  );

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    out_ready <= calm || ($urandom_range(99) >= 7);
  end

  task automatic send_word(input logic [WORD_W-1:0] geno, input logic last);
    while (!calm && $urandom_range(99) < 7) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= '{geno_word: geno, last_word: last};
    do @(posedge clk_i); while (!in_ready);
    words_sent++;
  endtask

  task automatic write_sample_count(input logic [31:0] value);
    in_valid <= 1'b0;
    psel     <= 1'b1;
    penable  <= 1'b0;
    pwrite   <= 1'b1;
    paddr    <= REG_SAMPLE_COUNT;
    pwdata   <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // wait for every marker result, then let the core settle
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // well-formed marker: called codes (01 at missing_pct), 00 to the end of the last byte, 01 after it
  task automatic send_marker(input int unsigned n_samples, input int unsigned missing_pct);
    int unsigned       n_words;
    int unsigned       filled;
    int unsigned       s;
    logic [WORD_W-1:0] w;
    logic [1:0]        code;
    n_words = (n_samples == 0) ? 1 : (n_samples + 31) / 32;
    filled  = (n_samples + 3) / 4 * 4;
    for (int k = 0; k < n_words; k++) begin
      for (int j = 0; j < WORD_W / 2; j++) begin
        s = k * 32 + j;
        if (s < n_samples) begin
          case ($urandom_range(2))
            0:       code = CODE_HOM_REF;
            1:       code = CODE_HET;
            default: code = CODE_HOM_ALT;
          endcase
          if ($urandom_range(99) < missing_pct) code = CODE_MISSING;
        end else if (s < filled) begin
          code = CODE_HOM_REF;
        end else begin
          code = CODE_MISSING;
        end
        w[2*j +: 2] = code;
      end
      send_word(w, k == n_words - 1);
    end
  endtask

  task automatic send_noise();
    int unsigned len;
    len = $urandom_range(1, 3);
    for (int k = 0; k < len; k++) begin
      send_word({$urandom, $urandom}, k == len - 1);
    end
  endtask

  initial begin
    logic [31:0] cfg;
    int unsigned eff;
    int unsigned markers;
    int unsigned miss;
    int unsigned start;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // sample_count at its reset value of one
    send_word(MISSING_ALL, 1'b1);                 // no calls at all
    send_word('0, 1'b1);                          // padding byte codes counted then removed
    send_word('1, 1'b1);                          // frequency and call rate ratios above one, clipped to one
    send_word({MISSING_ALL[WORD_W-1:2], CODE_HOM_ALT}, 1'b1);  // correction exceeds sum
    send_word('1, 1'b0);
    send_word(MISSING_ALL, 1'b0);
    send_word(64'h0123_4567_89ab_cdef, 1'b1);
    send_marker(1, 0);
    send_marker(1, 100);
    drain();

    write_sample_count(32'd0);                    // no correction, call rate zero
    send_word('1, 1'b1);
    send_marker(0, 0);
    drain();

    write_sample_count(32'hffff_ffff);            // saturates to the maximum sample count
    send_marker(64, 20);
    send_noise();
    drain();

    write_sample_count(32'd3);
    send_marker(3, 0);
    send_marker(3, 50);
    drain();

    start = words_sent;
    while (words_sent - start < RANDOM_WORDS) begin
      case ($urandom_range(99)) inside
        [0:4]:   cfg = 32'd0;
        [5:9]:   cfg = $urandom;
        [10:24]: cfg = $urandom_range(1, 8);
        [25:39]: cfg = 32 * $urandom_range(1, 4) + $urandom_range(0, 2) - 1;
        default: cfg = $urandom_range(1, 160);
      endcase
      eff = (cfg[SAMPLE_W-1:0] > MAX_SAMPLES) ? MAX_SAMPLES : cfg[SAMPLE_W-1:0];
      write_sample_count(cfg);
      markers = $urandom_range(4, 16);
      for (int m = 0; m < markers; m++) begin
        calm = (words_sent - start >= 400) && (words_sent - start < 650);
        case ($urandom_range(9))
          0:       miss = 100;
          1:       miss = 0;
          default: miss = $urandom_range(0, 40);
        endcase
        if (eff <= 256 && $urandom_range(99) < 85) send_marker(eff, miss);
        else send_noise();
      end
      calm = 1'b0;
      drain();
    end

    if (fail_count == 0) begin
      $display("genotype_allele_frequency_core regression: pass");
    end else begin
      $display("genotype_allele_frequency_core regression: fail");
    end
    $finish;
  end

  initial begin
    #4ms;
    $display("genotype_allele_frequency_core regression: fail");
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/gaf_pkg.sv
hw/rtl/gaf_front.sv
hw/rtl/gaf_queue.sv
hw/rtl/gaf_divider.sv
hw/rtl/gaf_back.sv
hw/rtl/genotype_allele_frequency_core.sv
hw/rtl/gaf_checker.sv
tb/sv/allele_frequency_checker.sv
tb/sv/testbench.sv
